@@ rtl/core/stpg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package stpg_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DELAY_W     = 16;
  localparam int STEP_W      = 10;
  localparam int RAMP_W      = 16;
  localparam int TOTAL_W     = 16;
  localparam int LIM_W       = (COUNT_WIDTH > RAMP_W) ? COUNT_WIDTH : RAMP_W;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_ADDR_W-1:0] CFG_START_DELAY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DELAY_STEP  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_STEPS  = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [DELAY_W-1:0] START_DELAY_RST = 16'd4000;
  localparam logic [STEP_W-1:0]  DELAY_STEP_RST  = 10'd7;
  localparam logic [RAMP_W-1:0]  RAMP_STEPS_RST  = 16'd530;
  localparam logic [DELAY_W-1:0] DELAY_MIN       = 16'd1;
  localparam logic [DELAY_W-1:0] DELAY_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [DELAY_W-1:0] start_delay;
    logic [STEP_W-1:0]  delay_step;
    logic [RAMP_W-1:0]  ramp_steps;
  } cfg_t;

  typedef struct packed {
    logic               pulse;
    logic               dir;
    logic               busy;
    logic               done;
    logic [DELAY_W-1:0] delay;
  } res_t;

endpackage
`default_nettype wire

@@ rtl/core/stpg_cfg.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stpg_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [stpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [stpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output stpg_pkg::cfg_t                         cfg
);

  stpg_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delay <= stpg_pkg::START_DELAY_RST;
      cfg_r.delay_step  <= stpg_pkg::DELAY_STEP_RST;
      cfg_r.ramp_steps  <= stpg_pkg::RAMP_STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        stpg_pkg::CFG_START_DELAY: cfg_r.start_delay <= cfg_wdata[stpg_pkg::DELAY_W-1:0];
        stpg_pkg::CFG_DELAY_STEP:  cfg_r.delay_step  <= cfg_wdata[stpg_pkg::STEP_W-1:0];
        stpg_pkg::CFG_RAMP_STEPS:  cfg_r.ramp_steps  <= cfg_wdata[stpg_pkg::RAMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ rtl/core/stpg_ramp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stpg_ramp (
  input  wire logic [stpg_pkg::DELAY_W-1:0]     half_period,
  input  wire logic [stpg_pkg::STEP_W-1:0]      delay_step,
  input  wire logic [stpg_pkg::COUNT_WIDTH-1:0] step_index,
  input  wire logic [stpg_pkg::LIM_W-1:0]       fall_lim,
  input  wire logic [stpg_pkg::LIM_W-1:0]       rise_lim,
  output logic      [stpg_pkg::DELAY_W-1:0]     half_period_new
);

  logic [stpg_pkg::LIM_W-1:0]   idx_ext;
  logic [stpg_pkg::DELAY_W-1:0] inc_ext;
  logic [stpg_pkg::DELAY_W:0]   sum;

  assign idx_ext = stpg_pkg::LIM_W'(step_index);
  assign inc_ext = stpg_pkg::DELAY_W'(delay_step);
  assign sum     = {1'b0, half_period} + {1'b0, inc_ext};

  always_comb begin
    if (idx_ext < fall_lim) begin
      // accelerating: shorter half-period, floor of one tick
      if (half_period <= inc_ext) begin
        half_period_new = stpg_pkg::DELAY_MIN;
      end else begin
        half_period_new = half_period - inc_ext;
      end
    end else if (idx_ext > rise_lim) begin
      if (sum[stpg_pkg::DELAY_W]) begin
        half_period_new = stpg_pkg::DELAY_MAX;
      end else begin
        half_period_new = sum[stpg_pkg::DELAY_W-1:0];
      end
    end else begin
      half_period_new = half_period;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/stpg_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stpg_seq (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic                           op,
  input  wire logic                           dir_in,
  input  wire logic [stpg_pkg::TOTAL_W-1:0]   total_steps,
  input  wire stpg_pkg::cfg_t                 cfg,
  output stpg_pkg::res_t                      res
);

  localparam int CW = stpg_pkg::COUNT_WIDTH;
  localparam int DW = stpg_pkg::DELAY_W;
  localparam int LW = stpg_pkg::LIM_W;

  logic          active_r,   active_nxt;
  logic          dir_r,      dir_nxt;
  logic          pulse_r,    pulse_nxt;
  logic [CW-1:0] index_r,    index_nxt;
  logic [CW-1:0] total_r,    total_nxt;
  logic [DW-1:0] period_r,   period_nxt;
  logic [DW-1:0] ticks_r,    ticks_nxt;
  logic [LW-1:0] fall_lim;
  logic [LW-1:0] rise_lim;
  logic          done;

  logic [CW-1:0] total_cnt;
  logic [LW+1:0] n_ext;
  logic [LW+1:0] a_ext;
  logic [LW+1:0] n_half;
  logic [DW-1:0] start_period;
  logic [DW-1:0] ramp_period;

  stpg_ramp u_ramp (
    .half_period     (period_r),
    .delay_step      (cfg.delay_step),
    .step_index      (index_r),
    .fall_lim        (fall_lim),
    .rise_lim        (rise_lim),
    .half_period_new (ramp_period)
  );

  assign total_cnt    = CW'(total_steps);
  assign n_ext        = (LW+2)'(total_r);
  assign a_ext        = (LW+2)'(cfg.ramp_steps);
  assign n_half       = n_ext >> 1;
  assign start_period = (cfg.start_delay == '0) ? stpg_pkg::DELAY_MIN : cfg.start_delay;

  // ramp turning points from the move length and the current ramp setting
  always_comb begin
    if (n_ext > ((a_ext << 1) + (LW+2)'(1))) begin
      fall_lim = LW'(a_ext);
      rise_lim = LW'(n_ext - a_ext);
    end else begin
      fall_lim = LW'(n_half);
      rise_lim = LW'(n_ext - n_half);
    end
  end

  always_comb begin
    active_nxt   = active_r;
    dir_nxt      = dir_r;
    pulse_nxt    = pulse_r;
    index_nxt    = index_r;
    total_nxt    = total_r;
    period_nxt   = period_r;
    ticks_nxt    = ticks_r;
    done         = 1'b0;

    if (accept) begin
      if (op == stpg_pkg::OP_START) begin
        if (!active_r) begin
          dir_nxt    = dir_in;
          total_nxt  = total_cnt;
          index_nxt  = '0;
          period_nxt = start_period;
          pulse_nxt  = 1'b0;
          ticks_nxt  = '0;
          if (total_cnt == '0) begin
            done = 1'b1;
          end else begin
            active_nxt = 1'b1;
          end
        end
      end else if (active_r) begin
        if (ticks_r != '0) begin
          ticks_nxt = ticks_r - DW'(1);
        end else if (pulse_r) begin
          pulse_nxt = 1'b0;
          ticks_nxt = period_r - DW'(1);
          index_nxt = index_r + CW'(1);
        end else if (index_r >= total_r) begin
          active_nxt = 1'b0;
          done       = 1'b1;
        end else begin
          period_nxt = ramp_period;
          pulse_nxt  = 1'b1;
          ticks_nxt  = ramp_period - DW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      dir_r      <= 1'b0;
      pulse_r    <= 1'b0;
      index_r    <= '0;
      total_r    <= '0;
      period_r   <= stpg_pkg::START_DELAY_RST;
      ticks_r    <= '0;
    end else begin
      active_r   <= active_nxt;
      dir_r      <= dir_nxt;
      pulse_r    <= pulse_nxt;
      index_r    <= index_nxt;
      total_r    <= total_nxt;
      period_r   <= period_nxt;
      ticks_r    <= ticks_nxt;
    end
  end

  always_comb begin
    res.pulse = pulse_nxt;
    res.dir   = dir_nxt;
    res.busy  = active_nxt;
    res.done  = done;
    res.delay = period_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/stpg_out.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stpg_out (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              load,
  input  wire stpg_pkg::res_t                    res,
  output logic                                   ready,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [stpg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int PAD_W = stpg_pkg::OUT_TDATA_W - $bits(stpg_pkg::res_t);

  logic           valid_r;
  stpg_pkg::res_t res_r;

  assign ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, res_r.delay, res_r.done, res_r.busy,
                       res_r.dir, res_r.pulse};

endmodule
`default_nettype wire

@@ rtl/core/stepper_trapezoid_pulse_generator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Beat contents (lowest bit first)
// in_       in   tuser: operation; tdata: direction, total_steps
// out_      out  tdata: pulse_out, dir_out, busy_res, move_done, delay_now
// cfg_      in   cfg_addr 0 start_delay, 1 delay_step, 2 ramp_steps
//
// One input beat per cycle; its result is registered and shown the next cycle.
// The single output register sets the rate: in_tready is high whenever it is
// empty or being drained, so full throughput needs out_tready held high.
// Synchronous active-low reset clears the move state and loads default config.
module stepper_trapezoid_pulse_generator (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [stpg_pkg::IN_TDATA_W-1:0]   in_tdata,   // direction, total_steps
  input  wire logic                              in_tuser,   // operation
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [stpg_pkg::OUT_TDATA_W-1:0]  out_tdata,  // pulse, dir, busy, done, delay
  input  wire logic                              cfg_we,
  input  wire logic [stpg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [stpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  stpg_pkg::cfg_t cfg;
  stpg_pkg::res_t res;
  logic           accept;
  logic           ready;

  assign in_tready = ready;
  assign accept    = in_tvalid && ready;

  stpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  stpg_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_tuser),
    .dir_in      (in_tdata[0]),
    .total_steps (in_tdata[stpg_pkg::TOTAL_W:1]),
    .cfg         (cfg),
    .res         (res)
  );

  stpg_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .res        (res),
    .ready      (ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/core/stpg_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module stpg_chk (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [stpg_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat gave no result next cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("move_done while still busy");

  a_delay_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[19:4] != 16'd0)
    else $error("half-period of zero");

  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> !out_tdata[0])
    else $error("step pulse high while idle");

endmodule

bind stepper_trapezoid_pulse_generator stpg_chk u_stpg_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
